@@ sv/wadr_pkg.sv @@
// ----------------------------------------------------------------------------
// wadr_pkg: shared types and constants of the windowed access race detector
// Holds the item structs, operation and register codes, the control bundle
// that drives the slot cells, and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package wadr_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned TID_W   = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 1;

  // operation codes
  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_SYNC   = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETAIN = 1'b1;

  localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd100;
  localparam logic [TIME_W-1:0] RETAIN_RESET = 32'd1000;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] address;
    logic [TID_W-1:0]  thread_num;
    logic              write_op;
    logic [TIME_W-1:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic race_flag;
    logic conflict_now;
    logic table_full;
  } out_item_t;

  // control bundle broadcast to every cell
  typedef struct packed {
    logic cmp;   // evaluate the held item against the slot
    logic upd;   // commit the update phase
    logic sync;  // item is a synchronization point
    logic hold;  // some slot conflicted, leave the table alone
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

endpackage

`default_nettype wire

@@ sv/wadr_cell.sv @@
// ----------------------------------------------------------------------------
// wadr_cell: one slot of the access table
// Holds one stored access, checks the held item against it in the compare
// phase and commits in the update phase; the free-slot token ripples along
// the row so the lowest free slot takes the access.
// ----------------------------------------------------------------------------
`default_nettype none

module wadr_cell (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire wadr_pkg::cell_ctrl_t       ctrl,
  input  wire wadr_pkg::in_item_t         item,
  input  wire logic [wadr_pkg::TIME_W-1:0] window_ticks,
  input  wire logic [wadr_pkg::TIME_W-1:0] retain_ticks,
  input  wire logic                       taken_in,
  output logic                            taken_out,
  output logic                            conflict
);

  logic                        valid;
  logic [wadr_pkg::ADDR_W-1:0] address;
  logic [wadr_pkg::TID_W-1:0]  thread;
  logic                        write;
  logic [wadr_pkg::TIME_W-1:0] stamp;

  logic                        live;
  logic                        drop;

  logic [wadr_pkg::TIME_W-1:0] age;
  logic                        live_now;
  logic                        same_addr;
  logic                        take;

  assign age       = item.timestamp - stamp;
  assign live_now  = valid && (age <= retain_ticks);
  assign same_addr = (address == item.address);

  // a slot that is not live is free; first free slot along the row wins
  assign take      = !live && !taken_in;
  assign taken_out = taken_in || !live;

  // compare phase flags
  always_ff @(posedge clk) begin
    if (rst) begin
      live     <= 1'b0;
      drop     <= 1'b0;
      conflict <= 1'b0;
    end else if (ctrl.cmp) begin
      live     <= live_now;
      drop     <= valid && same_addr && !live_now;
      conflict <= live_now && same_addr && (thread != item.thread_num) &&
                  (item.write_op || write) && (age < window_ticks);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.upd) begin
      if (ctrl.sync) begin
        valid <= 1'b0;
      end else if (!ctrl.hold) begin
        if (take) begin
          valid <= 1'b1;
        end else if (drop) begin
          valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.upd && !ctrl.sync && !ctrl.hold && take) begin
      address <= item.address;
      thread  <= item.thread_num;
      write   <= item.write_op;
      stamp   <= item.timestamp;
    end
  end

endmodule

`default_nettype wire

@@ sv/windowed_access_race_detector_top.sv @@
// ----------------------------------------------------------------------------
// windowed_access_race_detector_top: table based memory access race checker
// Row of slot cells with a small compare/update sequencer and an output
// register; one result item per input item.
// ----------------------------------------------------------------------------
// Each input item passes through a compare state, in which every slot cell
// checks the held item against its own stored access in parallel, and then
// an update state, in which the free-slot token ripples through the row and
// the table, the sticky race flag and the result register are written. The
// next item is accepted in the update state of the previous one; a result
// that waits in the output register holds the update state of the following
// item. Configuration writes are taken at any time, but are meant to land
// only while no item is in flight. After reset the table is empty and no
// clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_access_race_detector_top #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire wadr_pkg::in_item_t            in_data,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output wadr_pkg::out_item_t                out_data,
  // configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [wadr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [wadr_pkg::CFG_W-1:0]    cfg_data
);

  // configuration registers
  logic [wadr_pkg::TIME_W-1:0] window_ticks;
  logic [wadr_pkg::TIME_W-1:0] retain_ticks;

  // sequencer
  wadr_pkg::state_t state;
  wadr_pkg::state_t state_next;

  wadr_pkg::in_item_t   item;         // item under work
  wadr_pkg::cell_ctrl_t ctrl;
  logic                 sticky_race;

  logic                     accept;
  logic                     out_free;   // result register can take a value
  logic                     upd_fire;   // update cycle completes
  logic                     conflict_any;
  logic [TABLE_ENTRIES-1:0] conflict_vec;
  logic [TABLE_ENTRIES:0]   taken;      // free-slot token along the row

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= wadr_pkg::WINDOW_RESET;
      retain_ticks <= wadr_pkg::RETAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        wadr_pkg::CFG_WINDOW: window_ticks <= cfg_data;
        wadr_pkg::CFG_RETAIN: retain_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer: idle -> compare -> update, update may overlap the next accept
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid || !out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wadr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    upd_fire   = 1'b0;
    case (state)
      wadr_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = wadr_pkg::ST_CMP;
        end
      end
      wadr_pkg::ST_CMP: begin
        state_next = wadr_pkg::ST_UPD;
      end
      wadr_pkg::ST_UPD: begin
        // wait here while the previous result still sits unclaimed
        if (out_free) begin
          upd_fire   = 1'b1;
          in_stall   = 1'b0;
          state_next = in_valid ? wadr_pkg::ST_CMP : wadr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wadr_pkg::ST_IDLE;
      end
    endcase
    // no item is taken while reset is held
    if (rst) begin
      in_stall = 1'b1;
    end
  end

  // item register, loaded on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
  end

  // ---------------------------------------------------------------------------
  // row of slot cells
  // ---------------------------------------------------------------------------
  assign conflict_any = |conflict_vec;

  assign ctrl.cmp  = (state == wadr_pkg::ST_CMP);
  assign ctrl.upd  = upd_fire;
  assign ctrl.sync = (item.operation == wadr_pkg::OP_SYNC);
  assign ctrl.hold = conflict_any;

  assign taken[0] = 1'b0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    wadr_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .item         (item),
      .window_ticks (window_ticks),
      .retain_ticks (retain_ticks),
      .taken_in     (taken[i]),
      .taken_out    (taken[i+1]),
      .conflict     (conflict_vec[i])
    );
  end

  // ---------------------------------------------------------------------------
  // sticky race flag and result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      sticky_race <= 1'b0;
    end else if (upd_fire && !ctrl.sync && conflict_any) begin
      sticky_race <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      if (ctrl.sync) begin
        out_data.race_flag    <= sticky_race;
        out_data.conflict_now <= 1'b0;
        out_data.table_full   <= 1'b0;
      end else begin
        out_data.race_flag    <= sticky_race || conflict_any;
        out_data.conflict_now <= conflict_any;
        // no slot left for the access when the token never got taken
        out_data.table_full   <= !conflict_any && !taken[TABLE_ENTRIES];
      end
    end
  end

endmodule

`default_nettype wire
